// ===== hdl/cartridge_bank_controller_core_macros.svh =====
// ----------------------------------------------------------------------------
// cartridge bank controller assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_CONTROLLER_CORE_MACROS_SVH
`define CARTRIDGE_BANK_CONTROLLER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define CBC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CBC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define CBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hdl/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// cartridge bank controller package
// result codes, mapper kinds and size decode helpers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbc_pkg;

	localparam int unsigned CfgIndexWidth = 2;

	localparam logic [CfgIndexWidth-1:0] CFG_CART_TYPE = 2'd0;
	localparam logic [CfgIndexWidth-1:0] CFG_ROM_SIZE  = 2'd1;
	localparam logic [CfgIndexWidth-1:0] CFG_RAM_SIZE  = 2'd2;

	typedef enum logic [2:0] {
		TGT_ROM         = 3'd0,
		TGT_SRAM        = 3'd1,
		TGT_OPEN        = 3'd2,
		TGT_RTC_LIVE    = 3'd3,
		TGT_RTC_LATCHED = 3'd4,
		TGT_REG_WRITE   = 3'd5
	} target_t;

	typedef enum logic [2:0] {
		MAP_NONE = 3'd0,
		MAP_MBC1 = 3'd1,
		MAP_MBC2 = 3'd2,
		MAP_MBC3 = 3'd3,
		MAP_MBC5 = 3'd4
	} mapper_t;

	function automatic mapper_t mapper_decode(input logic [7:0] cart_type);
		mapper_t m;
		m = MAP_NONE;
		if (cart_type >= 8'h01 && cart_type <= 8'h03) m = MAP_MBC1;
		else if (cart_type == 8'h05 || cart_type == 8'h06) m = MAP_MBC2;
		else if (cart_type >= 8'h10 && cart_type <= 8'h13) m = MAP_MBC3;
		else if (cart_type >= 8'h19 && cart_type <= 8'h1E) m = MAP_MBC5;
		return m;
	endfunction

	// rom holds 2 << code banks of 16 KiB, code saturates at 8
	function automatic logic [8:0] rom_bank_mask(input logic [3:0] code);
		logic [3:0] c;
		c = (code > 4'd8) ? 4'd8 : code;
		return 9'((10'd2 << c) - 10'd1);
	endfunction

	function automatic logic [16:0] ram_addr_mask(input logic [2:0] code);
		logic [16:0] m;
		case (code)
			3'd2:    m = 17'h01FFF;
			3'd3:    m = 17'h07FFF;
			3'd4:    m = 17'h1FFFF;
			3'd5:    m = 17'h0FFFF;
			default: m = 17'h00000;
		endcase
		return m;
	endfunction

endpackage

// ===== hdl/cbc_if.sv =====
// ----------------------------------------------------------------------------
// cartridge bank controller channels
// bus access, mapped result and configuration write channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cbc_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [15:0] address;
	logic [7:0]  data_in;

	modport source (output valid, command, address, data_in, input ready);
	modport sink (input valid, command, address, data_in, output ready);
endinterface

interface cbc_rsp_if;
	logic             valid;
	logic             ready;
	cbc_pkg::target_t target;
	logic [22:0]      rom_address;
	logic [16:0]      sram_address;
	logic             sram_write;
	logic [7:0]       write_data;
	logic             nibble_only;
	logic [7:0]       rtc_register;
	logic             rtc_capture;

	modport source (output valid, target, rom_address, sram_address, sram_write,
		write_data, nibble_only, rtc_register, rtc_capture, input ready);
	modport sink (input valid, target, rom_address, sram_address, sram_write,
		write_data, nibble_only, rtc_register, rtc_capture, output ready);
endinterface

interface cbc_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [cbc_pkg::CfgIndexWidth-1:0] index;
	logic [7:0]                         data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/cartridge_bank_controller_core.sv =====
// ----------------------------------------------------------------------------
// cartridge bank controller core
// an accepted access has its result in the output register in the next cycle
// throughput: one access per cycle, the output register stalls only on rsp.ready low
// the bank decode is a single pass of logic between the access and the output register
// reset: rom bank 1, ram bank, enable, mode and latch cleared, configuration zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "cartridge_bank_controller_core_macros.svh"

module cartridge_bank_controller_core (
	input  logic         clk,
	input  logic         arst_n,
	cbc_req_if.sink      req,
	cbc_rsp_if.source    rsp,
	cbc_cfg_if.sink      cfg
);

	logic [7:0] cart_type_q;
	logic [3:0] rom_size_q;
	logic [2:0] ram_size_q;

	logic [8:0] rom_bank_q, rom_bank_d;
	logic [7:0] ram_bank_q, ram_bank_d;
	logic       ram_en_q, ram_en_d;
	logic       adv_q, adv_d;
	logic       latched_q, latched_d;

	logic       out_valid_q;
	logic       accept;

	cbc_pkg::mapper_t mapper;
	logic [8:0]       rom_mask;
	logic [16:0]      ram_mask;
	logic [8:0]       rom_bank_sel;
	logic [7:0]       ram_bank_sel;

	cbc_pkg::target_t tgt;
	logic [22:0]      rom_addr;
	logic [16:0]      sram_addr;
	logic             sram_wr;
	logic [7:0]       wdata;
	logic             nibble;
	logic [7:0]       rtc_reg;
	logic             capture;

	logic             wr;
	logic [15:0]      a;
	logic [7:0]       v;

	assign wr = req.command;
	assign a  = req.address;
	assign v  = req.data_in;

	assign accept    = req.valid && req.ready;
	assign req.ready = !out_valid_q || rsp.ready;
	assign cfg.ready = 1'b1;

	assign mapper   = cbc_pkg::mapper_decode(cart_type_q);
	assign rom_mask = cbc_pkg::rom_bank_mask(rom_size_q);
	assign ram_mask = cbc_pkg::ram_addr_mask(ram_size_q);

	// rom bank for the current window
	always_comb begin
		rom_bank_sel = '0;
		case (mapper)
			cbc_pkg::MAP_MBC1: begin
				if (a[14]) rom_bank_sel = {2'b00, rom_bank_q[6:0]};
				else if (adv_q) rom_bank_sel = {2'b00, rom_bank_q[6:5], 5'b00000};
			end
			cbc_pkg::MAP_MBC2: begin
				if (a[14]) begin
					rom_bank_sel = (rom_bank_q[3:0] == 4'h0) ? 9'd1 : {5'b00000, rom_bank_q[3:0]};
				end
			end
			cbc_pkg::MAP_MBC3: begin
				if (a[14]) begin
					rom_bank_sel = (rom_bank_q[7:0] == 8'h00) ? 9'd1 : {1'b0, rom_bank_q[7:0]};
				end
			end
			default: begin
				if (a[14]) rom_bank_sel = rom_bank_q;
			end
		endcase
	end

	assign ram_bank_sel = (mapper == cbc_pkg::MAP_MBC1) ?
		(adv_q ? {6'b000000, ram_bank_q[1:0]} : 8'h00) : ram_bank_q;

	always_comb begin
		tgt        = cbc_pkg::TGT_OPEN;
		rom_addr   = '0;
		sram_addr  = '0;
		sram_wr    = 1'b0;
		wdata      = '0;
		nibble     = 1'b0;
		rtc_reg    = '0;
		capture    = 1'b0;
		rom_bank_d = rom_bank_q;
		ram_bank_d = ram_bank_q;
		ram_en_d   = ram_en_q;
		adv_d      = adv_q;
		latched_d  = latched_q;

		if (!a[15]) begin
			if (wr) begin
				tgt = cbc_pkg::TGT_REG_WRITE;
				case (mapper)
					cbc_pkg::MAP_MBC1: begin
						case (a[14:13])
							2'b00: ram_en_d = (v[3:0] == 4'hA);
							2'b01: rom_bank_d = {2'b00, rom_bank_q[6:5],
								(v[4:0] == 5'd0) ? 5'd1 : v[4:0]};
							2'b10: begin
								rom_bank_d = {2'b00, v[1:0], rom_bank_q[4:0]};
								ram_bank_d = {6'b000000, v[1:0]};
							end
							default: adv_d = v[0];
						endcase
					end
					cbc_pkg::MAP_MBC2: begin
						if (!a[14]) begin
							if (a[8]) rom_bank_d = {5'b00000, v[3:0]};
							else ram_en_d = (v[3:0] == 4'hA);
						end
					end
					cbc_pkg::MAP_MBC3: begin
						case (a[14:13])
							2'b00: ram_en_d = (v[3:0] == 4'hA);
							2'b01: rom_bank_d = {1'b0, v};
							2'b10: ram_bank_d = v;
							default: begin
								if (v == 8'h00) begin
									latched_d = 1'b0;
								end else begin
									latched_d = 1'b1;
									rtc_reg   = ram_bank_q;
									capture   = 1'b1;
								end
							end
						endcase
					end
					cbc_pkg::MAP_MBC5: begin
						case (a[14:13])
							2'b00: ram_en_d = (v[3:0] == 4'hA);
							2'b01: begin
								if (a[12]) rom_bank_d = {v[0], rom_bank_q[7:0]};
								else rom_bank_d = {rom_bank_q[8], v};
							end
							2'b10: ram_bank_d = v;
							default: ;
						endcase
					end
					default: ;
				endcase
			end else begin
				tgt = cbc_pkg::TGT_ROM;
				if (mapper == cbc_pkg::MAP_NONE) rom_addr = {8'h00, a[14:0]};
				else rom_addr = {rom_bank_sel & rom_mask, a[13:0]};
			end
		end else if (a[15:13] == 3'b101 && ram_en_q && mapper != cbc_pkg::MAP_NONE) begin
			if (mapper == cbc_pkg::MAP_MBC2) begin
				// 512 nibbles mirrored across the window
				tgt       = cbc_pkg::TGT_SRAM;
				sram_addr = {8'h00, a[8:0]};
				nibble    = 1'b1;
				if (wr) begin
					sram_wr = 1'b1;
					wdata   = {4'h0, v[3:0]};
				end
			end else if (mapper == cbc_pkg::MAP_MBC3 && ram_bank_q > 8'h03) begin
				if (ram_bank_q >= 8'h08 && ram_bank_q <= 8'h0C) begin
					tgt = (!wr && latched_q) ? cbc_pkg::TGT_RTC_LATCHED : cbc_pkg::TGT_RTC_LIVE;
					rtc_reg = ram_bank_q;
					if (wr) wdata = v;
				end
			end else if (ram_mask != 17'h00000) begin
				tgt       = cbc_pkg::TGT_SRAM;
				sram_addr = {ram_bank_sel[3:0], a[12:0]} & ram_mask;
				if (wr) begin
					sram_wr = 1'b1;
					wdata   = v;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_type_q <= '0;
			rom_size_q  <= '0;
			ram_size_q  <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				cbc_pkg::CFG_CART_TYPE: cart_type_q <= cfg.data;
				cbc_pkg::CFG_ROM_SIZE:  rom_size_q  <= cfg.data[3:0];
				cbc_pkg::CFG_RAM_SIZE:  ram_size_q  <= cfg.data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q <= 9'd1;
			ram_bank_q <= '0;
			ram_en_q   <= 1'b0;
			adv_q      <= 1'b0;
			latched_q  <= 1'b0;
		end else if (accept) begin
			rom_bank_q <= rom_bank_d;
			ram_bank_q <= ram_bank_d;
			ram_en_q   <= ram_en_d;
			adv_q      <= adv_d;
			latched_q  <= latched_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp.target       <= tgt;
			rsp.rom_address  <= rom_addr;
			rsp.sram_address <= sram_addr;
			rsp.sram_write   <= sram_wr;
			rsp.write_data   <= wdata;
			rsp.nibble_only  <= nibble;
			rsp.rtc_register <= rtc_reg;
			rsp.rtc_capture  <= capture;
		end
	end

	assign rsp.valid = out_valid_q;

	`CBC_ASSERT_NEXT(a_transfer_gives_result, clk, arst_n, req.valid && req.ready, rsp.valid, "accepted access produced no result")
	`CBC_ASSERT_SAME(a_ready_only_on_stall, clk, arst_n, !req.ready, rsp.valid && !rsp.ready, "access refused without output stall")
	`CBC_ASSERT_SAME(a_nibble_on_sram, clk, arst_n, rsp.valid && rsp.nibble_only, rsp.target == cbc_pkg::TGT_SRAM, "nibble flag outside sram result")

endmodule
